[rtl/buzzer_tone_filter_chain_assert.svh]
// Assertion macros for the buzzer tone filter chain RTL.
`ifndef BUZZER_TONE_FILTER_CHAIN_ASSERT_SVH
`define BUZZER_TONE_FILTER_CHAIN_ASSERT_SVH
`ifndef SYNTH
`define BTFC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BTFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BTFC_ASSERT(lbl, clk, rst_n, prop, msg)
`define BTFC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/btfc_pkg.sv]
// Shared types, constants and coefficient ROM of the buzzer tone filter chain.
`timescale 1ns / 1ps
package btfc_pkg;

    localparam int SIG_W      = 32;
    localparam int COEF_W     = 24;
    localparam int PROD_W     = 56;
    localparam int ACC_W      = 64;
    localparam int HIST_DEPTH = 12;
    localparam int HIST_AW    = 4;
    localparam int DUTY_W     = 17;
    localparam int PCM_W      = 16;
    localparam int CNT_W      = 7;
    localparam int MAX_POP    = 64;

    localparam logic [1:0] MODEL_NONE = 2'd0;
    localparam logic [1:0] MODEL_A    = 2'd1;
    localparam logic [1:0] MODEL_B    = 2'd2;

    localparam logic [7:0] CFG_MODEL = 8'd0;
    localparam logic [7:0] CFG_CPS   = 8'd1;

    localparam logic signed [COEF_W-1:0] GAIN_PLAIN = 24'sd2516582;
    localparam logic signed [COEF_W-1:0] GAIN_A     = 24'sd2097152;
    localparam logic signed [COEF_W-1:0] GAIN_B     = 24'sd754975;

    localparam logic signed [COEF_W-1:0] COEF_ROM [30] = '{
        24'sd3939089, -24'sd7878178, 24'sd3939089, -24'sd7725275, 24'sd3836790,
        24'sd3981971, -24'sd7963942, 24'sd3981971, -24'sd7954676, 24'sd3778906,
        24'sd375214,   24'sd750428,  24'sd375214,  -24'sd2052976, -24'sd640471,
        24'sd3613778, -24'sd7227556, 24'sd3613778, -24'sd6887410, 24'sd3373396,
        24'sd4324394, -24'sd7164269, 24'sd3909269, -24'sd7164269, 24'sd4039358,
        24'sd5150681, -24'sd5523166, 24'sd2837849, -24'sd5523166, 24'sd3794227
    };

    typedef enum logic [3:0] {
        F_IDLE, F_DIV, F_BLK_MUL, F_BLK_ACC, F_BLK_RND, F_BQ_RD, F_BQ_MUL,
        F_BQ_ACC, F_BQ_RND, F_BQ_WR, F_GAIN_MUL, F_PCM1, F_PCM2, F_PUSH
    } t_fstate;

    typedef enum logic [1:0] {R_IDLE, R_EMPTY, R_RD, R_OUT} t_rstate;

    typedef struct packed {
        logic             valid;
        logic [PCM_W-1:0] sample;
    } t_push;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
    } t_drain;

    function automatic logic signed [COEF_W-1:0] coef(input logic sel_b,
                                                       input logic [1:0] stage,
                                                       input logic [2:0] k);
        logic [4:0] idx;
        idx = 5'(sel_b ? 15 : 0) + 5'({stage, 2'b00}) + 5'(stage) + 5'(k);
        return COEF_ROM[idx];
    endfunction

endpackage

[rtl/buzzer_tone_filter_chain.sv]
// Top level of the buzzer tone filter chain: configuration, dispatch, filter and ring.
`timescale 1ns / 1ps
// A sample request (tuser 0) turns the buzzer high time into a duty, runs it through the
// DC blocker and, for models A and B, three biquads, then pushes one 16-bit sample into
// the ring, using the 32-step radix-2 duty divider and the single shared multiplier that
// walks the biquad terms through the history RAM, reading, multiplying and accumulating
// each term in turn. A drain request (tuser 1) pops up to 64 samples oldest-first, each
// read from the ring RAM and then moved into the output register once that is free; an
// empty drain gives one result flagged in tuser. The output register lets the next
// request enter while the last result is still waiting. No clearing pass is needed
// after reset; configuration writes are taken every cycle.
module buzzer_tone_filter_chain import btfc_pkg::*; #(
    parameter int SAMPLE_RATE = 48000,
    parameter int RING_DEPTH  = 32768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // high_time[15:0], drain_count[22:16], zero
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // sample_value[15:0]
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,   // nothing_available
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    logic [1:0]  r_model;
    logic [15:0] r_cps;
    logic        cfg_we, accept, filt_busy, ring_busy, hist_clr;
    t_push       push;
    t_drain      drain;

    assign o_cfg_ready   = 1'b1;
    assign cfg_we        = i_cfg_valid && o_cfg_ready;
    assign hist_clr      = cfg_we && (i_cfg_index == CFG_MODEL);
    assign s_axis_tready = !filt_busy && !ring_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign drain.start   = accept && s_axis_tuser;
    assign drain.count   = s_axis_tdata[22:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model <= MODEL_NONE;
            r_cps   <= 16'd75;
        end else if (cfg_we) begin
            if (i_cfg_index == CFG_MODEL) r_model <= i_cfg_data[1:0];
            if (i_cfg_index == CFG_CPS)   r_cps   <= i_cfg_data;
        end
    end

    btfc_filter #(.SAMPLE_RATE(SAMPLE_RATE)) u_filter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept && !s_axis_tuser),
        .i_high     (s_axis_tdata[15:0]),
        .i_cps      (r_cps),
        .i_model    (r_model),
        .i_hist_clr (hist_clr),
        .o_busy     (filt_busy),
        .o_push     (push)
    );

    btfc_ring #(.DEPTH(RING_DEPTH)) u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_drain  (drain),
        .o_busy   (ring_busy),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast),
        .o_tuser  (m_axis_tuser)
    );
endmodule

[rtl/btfc_ram.sv]
// Generic simple dual port RAM with registered read.
`timescale 1ns / 1ps
module btfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/btfc_div.sv]
// Radix-2 restoring divider for the duty, saturated at one in Q1.16.
`timescale 1ns / 1ps
module btfc_div import btfc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [15:0]       i_high,
    input  logic [15:0]       i_cps,
    output logic              o_done,
    output logic [DUTY_W-1:0] o_duty
);
    logic [15:0] r_rem;
    logic [31:0] r_quo;
    logic [15:0] r_div;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [16:0] trial;
    logic        fits;

    always_comb begin
        trial = {r_rem, r_quo[31]} - {1'b0, r_div};
        fits  = ({r_rem, r_quo[31]} >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd31;
                r_rem  <= 16'd0;
                r_quo  <= {i_high, 16'd0};
                r_div  <= (i_cps == 16'd0) ? 16'd1 : i_cps;
            end else if (r_busy) begin
                r_rem <= fits ? trial[15:0] : {r_rem[14:0], r_quo[31]};
                r_quo <= {r_quo[30:0], fits};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_duty = ((|r_quo[31:17]) || (r_quo[16] && (|r_quo[15:0])))
                    ? 17'h10000 : r_quo[16:0];
endmodule

[rtl/btfc_filter.sv]
// DC blocker, biquad cascade over a history RAM, gain and PCM rounding.
`timescale 1ns / 1ps
module btfc_filter import btfc_pkg::*; #(
    parameter int SAMPLE_RATE = 48000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_high,
    input  logic [15:0] i_cps,
    input  logic [1:0]  i_model,
    input  logic        i_hist_clr,
    output logic        o_busy,
    output t_push       o_push
);
    localparam longint HP_L = 64'sd4194304
                              - (64'sd527071766 + SAMPLE_RATE / 2) / SAMPLE_RATE;
    localparam logic signed [COEF_W-1:0] HP = COEF_W'(HP_L);
    localparam logic signed [PROD_W-1:0] PLIM = 56'sh400000000000;

    t_fstate r_state, n_state;

    logic [DUTY_W-1:0]        r_duty, r_prev_in;
    logic signed [SIG_W-1:0]  r_prev_out, r_x, r_y, r_h0, r_h2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [1:0]               r_st, r_w;
    logic [2:0]               r_k;
    logic [HIST_AW-1:0]       r_raddr;
    logic [HIST_DEPTH-1:0]    r_valid;
    logic [46:0]              r_mag;
    logic                     r_neg;
    logic [PCM_W-1:0]         r_pcm;

    logic                     div_done;
    logic [DUTY_W-1:0]        div_duty;
    logic                     filt;
    logic signed [COEF_W-1:0] gain, ma;
    logic signed [SIG_W-1:0]  mb, hist_rd, oper, wdata;
    logic [HIST_AW-1:0]       rd_addr;
    logic                     hist_we;
    logic signed [17:0]       diff;
    logic signed [PROD_W-1:0] negp;
    logic [61:0]              scaled;
    logic [PCM_W-1:0]         mag_s;

    function automatic logic signed [SIG_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] t;
        t = a + 64'sd2097152;
        if (t[63:53] != {11{t[53]}}) begin
            return t[63] ? 32'sh80000000 : 32'sh7fffffff;
        end
        return t[53:22];
    endfunction

    btfc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_high  (i_high),
        .i_cps   (i_cps),
        .o_done  (div_done),
        .o_duty  (div_duty)
    );

    btfc_ram #(.WIDTH(SIG_W), .DEPTH(HIST_DEPTH)) u_hist (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr ({r_st, r_w}),
        .i_wdata (wdata),
        .i_raddr (rd_addr),
        .o_rdata (hist_rd)
    );

    always_comb begin
        filt    = (i_model == MODEL_A) || (i_model == MODEL_B);
        gain    = (i_model == MODEL_A) ? GAIN_A : (i_model == MODEL_B) ? GAIN_B : GAIN_PLAIN;
        rd_addr = HIST_AW'({r_st, 2'b00}) + HIST_AW'(r_k - 3'd1);
        oper    = (r_k == 3'd0) ? r_x : (r_valid[r_raddr] ? hist_rd : '0);
        hist_we = (r_state == F_BQ_WR);
        diff    = $signed({1'b0, r_duty}) - $signed({1'b0, r_prev_in});
        negp    = -r_prod;
        scaled  = ({15'd0, r_mag} << 15) - {15'd0, r_mag} + 62'h200000000000;
        mag_s   = scaled[61:46];
        unique case (r_w)
            2'd0:    wdata = r_x;
            2'd1:    wdata = r_h0;
            2'd2:    wdata = r_y;
            default: wdata = r_h2;
        endcase
        unique case (r_state)
            F_BLK_MUL: begin
                ma = HP;
                mb = r_prev_out;
            end
            F_GAIN_MUL: begin
                ma = gain;
                mb = r_x;
            end
            default: begin
                ma = coef(i_model == MODEL_B, r_st, r_k);
                mb = oper;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE:     if (i_start) n_state = F_DIV;
            F_DIV:      if (div_done) n_state = F_BLK_MUL;
            F_BLK_MUL:  n_state = F_BLK_ACC;
            F_BLK_ACC:  n_state = F_BLK_RND;
            F_BLK_RND:  n_state = filt ? F_BQ_RD : F_GAIN_MUL;
            F_BQ_RD:    n_state = F_BQ_MUL;
            F_BQ_MUL:   n_state = F_BQ_ACC;
            F_BQ_ACC:   n_state = (r_k == 3'd4) ? F_BQ_RND : F_BQ_RD;
            F_BQ_RND:   n_state = F_BQ_WR;
            F_BQ_WR: begin
                if (r_w == 2'd3) begin
                    n_state = (r_st == 2'd2) ? F_GAIN_MUL : F_BQ_RD;
                end
            end
            F_GAIN_MUL: n_state = F_PCM1;
            F_PCM1:     n_state = F_PCM2;
            F_PCM2:     n_state = F_PUSH;
            F_PUSH:     n_state = F_IDLE;
            default:    n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_in  <= '0;
            r_prev_out <= '0;
            r_valid    <= '0;
        end else begin
            if (i_hist_clr) begin
                r_valid <= '0;
            end else if (hist_we) begin
                r_valid[{r_st, r_w}] <= 1'b1;
            end
            unique case (r_state)
                F_DIV:      r_duty <= div_duty;
                F_BLK_MUL:  r_prod <= ma * mb;
                F_BLK_ACC:  r_acc <= (ACC_W'(diff) <<< 30) + ACC_W'(r_prod);
                F_BLK_RND: begin
                    r_x        <= round_sat(r_acc);
                    r_prev_out <= round_sat(r_acc);
                    r_prev_in  <= r_duty;
                    r_st       <= 2'd0;
                    r_k        <= 3'd0;
                end
                F_BQ_RD:    r_raddr <= rd_addr;
                F_BQ_MUL: begin
                    r_prod <= ma * mb;
                    if (r_k == 3'd1) r_h0 <= oper;
                    if (r_k == 3'd3) r_h2 <= oper;
                end
                F_BQ_ACC: begin
                    if (r_k >= 3'd3) begin
                        r_acc <= r_acc - ACC_W'(r_prod);
                    end else if (r_k == 3'd0) begin
                        r_acc <= ACC_W'(r_prod);
                    end else begin
                        r_acc <= r_acc + ACC_W'(r_prod);
                    end
                    r_k <= r_k + 3'd1;
                end
                F_BQ_RND: begin
                    r_y <= round_sat(r_acc);
                    r_w <= 2'd0;
                end
                F_BQ_WR: begin
                    r_w <= r_w + 2'd1;
                    if (r_w == 2'd3) begin
                        r_x  <= r_y;
                        r_st <= r_st + 2'd1;
                        r_k  <= 3'd0;
                    end
                end
                F_GAIN_MUL: r_prod <= ma * mb;
                F_PCM1: begin
                    r_neg <= r_prod[PROD_W-1];
                    if (r_prod > PLIM || r_prod < -PLIM) begin
                        r_mag <= 47'h400000000000;
                    end else begin
                        r_mag <= r_prod[PROD_W-1] ? negp[46:0] : r_prod[46:0];
                    end
                end
                F_PCM2:     r_pcm <= r_neg ? -mag_s : mag_s;
                default: ;
            endcase
        end
    end

    assign o_busy        = (r_state != F_IDLE);
    assign o_push.valid  = (r_state == F_PUSH);
    assign o_push.sample = r_pcm;
endmodule

[rtl/btfc_ring.sv]
// Sample ring with drop-oldest push and a drain sequencer feeding the output register.
`timescale 1ns / 1ps
module btfc_ring import btfc_pkg::*; #(
    parameter int DEPTH = 32768
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_push            i_push,
    input  t_drain           i_drain,
    output logic             o_busy,
    output logic             o_tvalid,
    input  logic             i_tready,
    output logic [PCM_W-1:0] o_tdata,
    output logic             o_tlast,
    output logic             o_tuser
);
    `include "buzzer_tone_filter_chain_assert.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int SW = FW + 1;

    t_rstate r_state, n_state;

    logic [AW-1:0]    r_head;
    logic [FW-1:0]    r_fill;
    logic [CNT_W-1:0] r_left;
    logic             r_ovalid, r_olast, r_onone;
    logic [PCM_W-1:0] r_odata;

    logic             full, slot_free;
    logic [SW-1:0]    wsum;
    logic [AW-1:0]    widx, head_inc;
    logic [CNT_W-1:0] want, take;
    logic [PCM_W-1:0] rdata;

    always_comb begin
        full      = (r_fill == FW'(DEPTH));
        head_inc  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
        wsum      = SW'(r_head) + SW'(r_fill);
        if (wsum >= SW'(DEPTH)) wsum = wsum - SW'(DEPTH);
        widx      = full ? r_head : wsum[AW-1:0];
        want      = (i_drain.count > CNT_W'(MAX_POP)) ? CNT_W'(MAX_POP) : i_drain.count;
        take      = (FW'(want) < r_fill) ? want : r_fill[CNT_W-1:0];
        slot_free = !r_ovalid || i_tready;
    end

    btfc_ram #(.WIDTH(PCM_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_push.valid),
        .i_waddr (widx),
        .i_wdata (i_push.sample),
        .i_raddr (r_head),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            R_IDLE: begin
                if (i_drain.start) n_state = (take == '0) ? R_EMPTY : R_RD;
            end
            R_EMPTY: if (slot_free) n_state = R_IDLE;
            R_RD:    n_state = R_OUT;
            R_OUT: begin
                if (slot_free) n_state = (r_left == CNT_W'(1)) ? R_IDLE : R_RD;
            end
            default: n_state = R_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= R_IDLE;
            r_head   <= '0;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (slot_free) r_ovalid <= (r_state == R_EMPTY) || (r_state == R_OUT);
            if (i_push.valid) begin
                if (full) begin
                    r_head <= head_inc;
                end else begin
                    r_fill <= r_fill + FW'(1);
                end
            end
            unique case (r_state)
                R_IDLE: if (i_drain.start) r_left <= take;
                R_EMPTY: begin
                    if (slot_free) begin
                        r_odata  <= '0;
                        r_olast  <= 1'b1;
                        r_onone  <= 1'b1;
                    end
                end
                R_OUT: begin
                    if (slot_free) begin
                        r_odata  <= rdata;
                        r_olast  <= (r_left == CNT_W'(1));
                        r_onone  <= 1'b0;
                        r_head   <= head_inc;
                        r_fill   <= r_fill - FW'(1);
                        r_left   <= r_left - CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_busy   = (r_state != R_IDLE);
    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_odata;
    assign o_tlast  = r_olast;
    assign o_tuser  = r_onone;

    `BTFC_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= FW'(DEPTH), "ring fill above depth")
    `BTFC_ASSERT(a_push_idle, i_clk, i_rst_n, i_push.valid |-> r_state == R_IDLE, "push during drain")
    `BTFC_ASSERT(a_none_last, i_clk, i_rst_n, (r_ovalid && r_onone) |-> (r_olast && r_odata == '0), "empty result not last")
    `BTFC_ASSERT(a_pop_nonempty, i_clk, i_rst_n, (r_state == R_OUT && slot_free) |-> r_fill != '0, "pop from empty ring")
endmodule
